@@ sv/adtp_pkg.sv @@
// ----------------------------------------------------------------------------
// adtp_pkg
// Types, codes and field-type tables shared by the advertising data parser.
// ----------------------------------------------------------------------------
package adtp_pkg;

    localparam int unsigned MAX_REPORT_BYTES_DEF = 510;

    typedef enum logic [3:0] {
        KIND_NONE       = 4'd0,
        KIND_LEVEL      = 4'd1,
        KIND_SVCDATA16  = 4'd2,
        KIND_SVCDATA128 = 4'd3,
        KIND_UUIDS16    = 4'd4,
        KIND_UUIDS128   = 4'd5,
        KIND_NAME       = 4'd6,
        KIND_TXPOWER    = 4'd7,
        KIND_MESH       = 4'd8,
        KIND_MANUF      = 4'd9,
        KIND_APPEARANCE = 4'd10,
        KIND_UNKNOWN    = 4'd11
    } kind_t;

    typedef enum logic [2:0] {
        ROLE_TYPE      = 3'd0,
        ROLE_LENGTH    = 3'd1,
        ROLE_UUID      = 3'd2,
        ROLE_MANUF_ID  = 3'd3,
        ROLE_VALUE     = 3'd4,
        ROLE_DISCARDED = 3'd5
    } role_t;

    typedef enum logic [2:0] {
        ST_FINE      = 3'd0,
        ST_TOO_LONG  = 3'd1,
        ST_LEG_ZERO  = 3'd2,
        ST_TRUNC_HDR = 3'd3,
        ST_OVERRUN   = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_SECOND = 2'd1,
        PH_VALUE  = 2'd2
    } phase_t;

    // type codes, new format
    localparam logic [7:0] TLV_LEVEL      = 8'h01;
    localparam logic [7:0] TLV_SVCDATA16  = 8'h03;
    localparam logic [7:0] TLV_SVCDATA128 = 8'h04;
    localparam logic [7:0] TLV_UUIDS16_A  = 8'h05;
    localparam logic [7:0] TLV_UUIDS16_B  = 8'h07;
    localparam logic [7:0] TLV_NAME_A     = 8'h0A;
    localparam logic [7:0] TLV_NAME_B     = 8'h0B;
    localparam logic [7:0] TLV_TXPOWER    = 8'h0C;
    localparam logic [7:0] TLV_MESH       = 8'h10;
    localparam logic [7:0] TYPE_MANUF     = 8'hFF;

    // type codes, legacy format
    localparam logic [7:0] LEG_LEVEL      = 8'h01;
    localparam logic [7:0] LEG_UUIDS16_A  = 8'h02;
    localparam logic [7:0] LEG_UUIDS16_B  = 8'h03;
    localparam logic [7:0] LEG_UUIDS128_A = 8'h06;
    localparam logic [7:0] LEG_UUIDS128_B = 8'h07;
    localparam logic [7:0] LEG_NAME_A     = 8'h08;
    localparam logic [7:0] LEG_NAME_B     = 8'h09;
    localparam logic [7:0] LEG_TXPOWER    = 8'h0A;
    localparam logic [7:0] LEG_SVCDATA16  = 8'h16;
    localparam logic [7:0] LEG_APPEAR     = 8'h19;
    localparam logic [7:0] LEG_SVCDATA128 = 8'h21;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_of_report;
        logic       last_of_report;
        logic [9:0] report_length;
        logic       legacy_format;
    } in_item_t;

    typedef struct packed {
        in_item_t item;
        kind_t    kind_tlv;
        kind_t    kind_leg;
    } q_item_t;

    typedef struct packed {
        logic       full;
        logic       not_empty;
    } q_status_t;

    typedef struct packed {
        logic [7:0] byte_out;
        logic [3:0] field_kind;
        logic [2:0] byte_role;
        logic [3:0] uuid_position;
        logic [7:0] value_offset;
        logic       field_valid;
        logic       field_end;
        logic       report_end;
        logic       report_ok;
        logic [2:0] status;
    } out_item_t;

    function automatic kind_t kind_of_tlv(input logic [7:0] t);
        kind_t k;
        case (t) inside
            TLV_LEVEL:                    k = KIND_LEVEL;
            TLV_SVCDATA16:                k = KIND_SVCDATA16;
            TLV_SVCDATA128:               k = KIND_SVCDATA128;
            TLV_UUIDS16_A, TLV_UUIDS16_B: k = KIND_UUIDS16;
            TLV_NAME_A, TLV_NAME_B:       k = KIND_NAME;
            TLV_TXPOWER:                  k = KIND_TXPOWER;
            TLV_MESH:                     k = KIND_MESH;
            TYPE_MANUF:                   k = KIND_MANUF;
            default:                      k = KIND_UNKNOWN;
        endcase
        return k;
    endfunction

    function automatic kind_t kind_of_leg(input logic [7:0] t);
        kind_t k;
        case (t) inside
            LEG_LEVEL:                      k = KIND_LEVEL;
            LEG_SVCDATA16:                  k = KIND_SVCDATA16;
            LEG_SVCDATA128:                 k = KIND_SVCDATA128;
            LEG_UUIDS16_A, LEG_UUIDS16_B:   k = KIND_UUIDS16;
            LEG_UUIDS128_A, LEG_UUIDS128_B: k = KIND_UUIDS128;
            LEG_NAME_A, LEG_NAME_B:         k = KIND_NAME;
            LEG_TXPOWER:                    k = KIND_TXPOWER;
            LEG_APPEAR:                     k = KIND_APPEARANCE;
            TYPE_MANUF:                     k = KIND_MANUF;
            default:                        k = KIND_UNKNOWN;
        endcase
        return k;
    endfunction

    // per-type length rule
    function automatic logic valid_of(input kind_t k, input logic [7:0] len);
        logic v;
        if (len == 8'd0) begin
            v = 1'b0;
        end else begin
            case (k)
                KIND_LEVEL, KIND_TXPOWER:                 v = (len == 8'd1);
                KIND_SVCDATA16, KIND_MANUF:               v = (len > 8'd2);
                KIND_SVCDATA128:                          v = (len > 8'd16);
                KIND_UUIDS16:                             v = (len[0] == 1'b0);
                KIND_UUIDS128:                            v = (len[3:0] == 4'd0);
                KIND_NAME, KIND_MESH, KIND_APPEARANCE:    v = 1'b1;
                default:                                  v = 1'b0;
            endcase
        end
        return v;
    endfunction

endpackage

@@ sv/adtp_front.sv @@
// ----------------------------------------------------------------------------
// adtp_front
// Input side: takes items while the queue has room and looks up the field
// kind of the byte under both formats, so the back end only selects.
// ----------------------------------------------------------------------------
module adtp_front
    import adtp_pkg::*;
(
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    input  q_status_t q_status,
    output logic      push,
    output q_item_t   push_item
);

    assign s_ready = !q_status.full;
    assign push    = s_valid && !q_status.full;

    always_comb begin
        push_item.item     = s_data;
        push_item.kind_tlv = kind_of_tlv(s_data.data_byte);
        push_item.kind_leg = kind_of_leg(s_data.data_byte);
    end

endmodule

@@ sv/adtp_queue.sv @@
// ----------------------------------------------------------------------------
// adtp_queue
// Two-entry queue between the classifier and the parser.
// ----------------------------------------------------------------------------
module adtp_queue
    import adtp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  q_item_t   push_item,
    input  logic      pop,
    output q_item_t   head_item,
    output q_status_t q_status
);

    q_item_t    entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign q_status.full      = (count_reg == 2'd2);
    assign q_status.not_empty = (count_reg != 2'd0);
    assign head_item          = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ sv/adtp_back.sv @@
// ----------------------------------------------------------------------------
// adtp_back
// Parser state machine: tags one byte per cycle from the queue head while
// the output is not stalled, and holds the tagged item in the output register.
// ----------------------------------------------------------------------------
module adtp_back
    import adtp_pkg::*;
#(
    parameter int unsigned MAX_REPORT_BYTES = MAX_REPORT_BYTES_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  q_item_t   head_item,
    input  q_status_t q_status,
    output logic      pop,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    localparam logic [9:0] MaxLen = 10'(MAX_REPORT_BYTES);

    phase_t     phase_reg, phase_next, phase_eff;
    logic [9:0] pos_reg, pos_next, pos_eff;
    logic [9:0] len_reg, len_next, len_eff;
    logic       leg_reg, leg_next, leg_eff;
    kind_t      kind_reg, kind_next, kind_eff;
    logic [7:0] vrem_reg, vrem_next, vrem_eff;
    logic [7:0] vidx_reg, vidx_next, vidx_eff;
    logic       fatal_reg, fatal_next, fatal_eff;
    logic       stop_reg, stop_next, stop_eff;
    logic       fok_reg, fok_next, fok_eff;
    status_t    status_reg, status_next, status_eff;

    logic       out_valid_reg;
    out_item_t  out_data_reg, out_data_next;

    in_item_t   it;
    logic       first, too_long, active, over, hdr_short;
    logic [7:0] b, leg_len, vrem_dec;
    logic       valid_tlv2, valid_leg2;

    assign it    = head_item.item;
    assign b     = it.data_byte;
    assign first = it.first_of_report;
    assign pop   = q_status.not_empty && (!out_valid_reg || m_ready);

    // a first byte restarts the report before it is parsed
    assign too_long   = (it.report_length > MaxLen);
    assign phase_eff  = first ? PH_HEADER : phase_reg;
    assign pos_eff    = first ? 10'd0 : pos_reg;
    assign len_eff    = first ? it.report_length : len_reg;
    assign leg_eff    = first ? it.legacy_format : leg_reg;
    assign kind_eff   = first ? KIND_UNKNOWN : kind_reg;
    assign vrem_eff   = first ? 8'd0 : vrem_reg;
    assign vidx_eff   = first ? 8'd0 : vidx_reg;
    assign fatal_eff  = first ? too_long : fatal_reg;
    assign stop_eff   = first ? too_long : stop_reg;
    assign fok_eff    = first ? 1'b0 : fok_reg;
    assign status_eff = first ? (too_long ? ST_TOO_LONG : ST_FINE) : status_reg;

    assign active     = !stop_eff && (pos_eff < len_eff);
    assign over       = ({1'b0, pos_eff} + 11'd1 + {3'b000, b}) > {1'b0, len_eff};
    assign hdr_short  = ({1'b0, pos_eff} + 11'd2) > {1'b0, len_eff};
    assign leg_len    = vrem_eff - 8'd1;
    assign vrem_dec   = vrem_eff - 8'd1;
    assign valid_tlv2 = valid_of(kind_eff, b);
    assign valid_leg2 = valid_of(head_item.kind_leg, leg_len);

    // next state
    always_comb begin
        phase_next  = phase_eff;
        pos_next    = pos_eff;
        len_next    = len_eff;
        leg_next    = leg_eff;
        kind_next   = kind_eff;
        vrem_next   = vrem_eff;
        vidx_next   = vidx_eff;
        fatal_next  = fatal_eff;
        stop_next   = stop_eff;
        fok_next    = fok_eff;
        status_next = status_eff;
        if (active) begin
            pos_next = pos_eff + 10'd1;
            case (phase_eff)
                PH_SECOND: begin
                    if (!leg_eff) begin
                        fok_next = valid_tlv2;
                        if (over) begin
                            if (status_eff == ST_FINE) status_next = ST_OVERRUN;
                            stop_next  = 1'b1;
                            phase_next = PH_HEADER;
                        end else if (b == 8'd0) begin
                            phase_next = PH_HEADER;
                        end else begin
                            vrem_next  = b;
                            vidx_next  = 8'd0;
                            phase_next = PH_VALUE;
                        end
                    end else begin
                        kind_next = head_item.kind_leg;
                        fok_next  = valid_leg2;
                        if (leg_len == 8'd0) begin
                            phase_next = PH_HEADER;
                        end else begin
                            vrem_next  = leg_len;
                            vidx_next  = 8'd0;
                            phase_next = PH_VALUE;
                        end
                    end
                end
                PH_VALUE: begin
                    vidx_next = vidx_eff + 8'd1;
                    vrem_next = vrem_dec;
                    if (vrem_dec == 8'd0) phase_next = PH_HEADER;
                end
                default: begin
                    phase_next = PH_HEADER;
                    if (hdr_short) begin
                        if (status_eff == ST_FINE) status_next = ST_TRUNC_HDR;
                        stop_next = 1'b1;
                    end else if (!leg_eff) begin
                        kind_next  = head_item.kind_tlv;
                        phase_next = PH_SECOND;
                    end else if (b == 8'd0) begin
                        if (status_eff == ST_FINE) status_next = ST_LEG_ZERO;
                        fatal_next = 1'b1;
                        stop_next  = 1'b1;
                    end else if (over) begin
                        if (status_eff == ST_FINE) status_next = ST_OVERRUN;
                        stop_next = 1'b1;
                    end else begin
                        vrem_next  = b;
                        phase_next = PH_SECOND;
                    end
                end
            endcase
        end
        if (it.last_of_report) stop_next = 1'b1;
    end

    // tagged result
    always_comb begin
        out_data_next               = '0;
        out_data_next.byte_out      = b;
        out_data_next.field_kind    = KIND_NONE;
        out_data_next.byte_role     = ROLE_DISCARDED;
        out_data_next.report_end    = it.last_of_report;
        out_data_next.report_ok     = it.last_of_report && !fatal_next;
        out_data_next.status        = status_next;
        if (active) begin
            case (phase_eff)
                PH_SECOND: begin
                    if (!leg_eff) begin
                        out_data_next.byte_role   = ROLE_LENGTH;
                        out_data_next.field_kind  = kind_eff;
                        out_data_next.field_valid = valid_tlv2 && !over;
                        out_data_next.field_end   = over || (b == 8'd0);
                    end else begin
                        out_data_next.byte_role   = ROLE_TYPE;
                        out_data_next.field_kind  = head_item.kind_leg;
                        out_data_next.field_valid = valid_leg2;
                        out_data_next.field_end   = (leg_len == 8'd0);
                    end
                end
                PH_VALUE: begin
                    out_data_next.field_kind   = kind_eff;
                    out_data_next.field_valid  = fok_eff;
                    out_data_next.byte_role    = ROLE_VALUE;
                    out_data_next.value_offset = vidx_eff;
                    out_data_next.field_end    = (vrem_dec == 8'd0);
                    // layout roles only in fields that pass their length rule
                    if (fok_eff) begin
                        case (kind_eff)
                            KIND_SVCDATA16: begin
                                if (vidx_eff < 8'd2) begin
                                    out_data_next.byte_role     = ROLE_UUID;
                                    out_data_next.uuid_position = vidx_eff[0] ? 4'd14 : 4'd15;
                                end
                            end
                            KIND_SVCDATA128: begin
                                if (vidx_eff < 8'd16) begin
                                    out_data_next.byte_role     = ROLE_UUID;
                                    out_data_next.uuid_position = vidx_eff[3:0];
                                end
                            end
                            KIND_UUIDS16: begin
                                out_data_next.byte_role     = ROLE_UUID;
                                out_data_next.uuid_position = vidx_eff[0] ? 4'd14 : 4'd15;
                            end
                            KIND_UUIDS128: begin
                                out_data_next.byte_role     = ROLE_UUID;
                                out_data_next.uuid_position = vidx_eff[3:0];
                            end
                            KIND_MANUF: begin
                                if (vidx_eff < 8'd2) out_data_next.byte_role = ROLE_MANUF_ID;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                default: begin
                    if (hdr_short) begin
                        out_data_next.byte_role = ROLE_DISCARDED;
                    end else if (!leg_eff) begin
                        out_data_next.field_kind = head_item.kind_tlv;
                        out_data_next.byte_role  = ROLE_TYPE;
                    end else begin
                        // legacy length byte; zero or overrunning length ends here
                        out_data_next.byte_role = ROLE_LENGTH;
                        out_data_next.field_end = (b == 8'd0) || over;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HEADER;
            pos_reg       <= 10'd0;
            len_reg       <= 10'd0;
            leg_reg       <= 1'b0;
            kind_reg      <= KIND_UNKNOWN;
            vrem_reg      <= 8'd0;
            vidx_reg      <= 8'd0;
            fatal_reg     <= 1'b0;
            stop_reg      <= 1'b0;
            fok_reg       <= 1'b0;
            status_reg    <= ST_FINE;
            out_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                phase_reg  <= phase_next;
                pos_reg    <= pos_next;
                len_reg    <= len_next;
                leg_reg    <= leg_next;
                kind_reg   <= kind_next;
                vrem_reg   <= vrem_next;
                vidx_reg   <= vidx_next;
                fatal_reg  <= fatal_next;
                stop_reg   <= stop_next;
                fok_reg    <= fok_next;
                status_reg <= status_next;
            end
            if (pop) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

@@ sv/adv_data_tlv_parser.sv @@
// ----------------------------------------------------------------------------
// adv_data_tlv_parser
// Advertising report field parser: tags each report byte with its field
// kind, role, UUID position, value offset and validity.
// ----------------------------------------------------------------------------
//  channel   ports                       payload      direction
//  input     s_valid, s_ready, s_data    in_item_t    in
//  result    m_valid, m_ready, m_data    out_item_t   out
//
//  One item per cycle sustained while m_ready holds; each item's result
//  passes the classifier into the two-entry queue, then the parser into
//  the output register. The parser's byte-wide state loop sets the rate.
//  aresetn is synchronous and active low; it empties the queue and the
//  output register and returns the parser to the header phase.
//  A stalled result holds the parser; the queue takes items until both entries are full.
// ----------------------------------------------------------------------------
module adv_data_tlv_parser
    import adtp_pkg::*;
#(
    parameter int unsigned MAX_REPORT_BYTES = MAX_REPORT_BYTES_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    q_status_t q_status;
    logic      push, pop;
    q_item_t   push_item, head_item;

    adtp_front u_front (
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .q_status  (q_status),
        .push      (push),
        .push_item (push_item)
    );

    adtp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .q_status  (q_status)
    );

    adtp_back #(
        .MAX_REPORT_BYTES (MAX_REPORT_BYTES)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head_item (head_item),
        .q_status  (q_status),
        .pop       (pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // an accepted item is in the queue on the following cycle
    a_push_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> q_status.not_empty)
        else $error("accepted item missing from queue");

    a_ok_on_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (!m_data.report_ok || m_data.report_end))
        else $error("report_ok without report_end");

    a_discard_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.byte_role == ROLE_DISCARDED)
            |-> (!m_data.field_valid && m_data.field_kind == KIND_NONE))
        else $error("discarded item carries field tags");

    a_uuid_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.byte_role == ROLE_UUID)
            |-> (m_data.field_valid && (m_data.field_kind == KIND_SVCDATA16
                || m_data.field_kind == KIND_SVCDATA128
                || m_data.field_kind == KIND_UUIDS16
                || m_data.field_kind == KIND_UUIDS128)))
        else $error("uuid byte outside a valid uuid field");

endmodule
